// File: design/b64e_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the 6-bit to ASCII character map of the
// Base64 encoder.
// ---------------------------------------------------------------------------
package b64e_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // Position within the current 3-byte group.
    typedef enum logic [2:0] {
        PH_0 = 3'b001,
        PH_1 = 3'b010,
        PH_2 = 3'b100
    } phase_t;

    // One classified input byte: up to four characters and the index of the
    // last one that is valid.
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [1:0]      last_idx;
        logic            fin;
    } grp_t;

    // Queue status seen by the front and back parts.
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [7:0] enc6(input logic [5:0] v);
        logic [7:0] c;
        c = 8'h2F;
        case (v) inside
            [6'd0:6'd25]:  c = 8'h41 + {2'b00, v};
            [6'd26:6'd51]: c = 8'h61 + {2'b00, v} - 8'd26;
            [6'd52:6'd61]: c = 8'h30 + {2'b00, v} - 8'd52;
            6'd62:         c = 8'h2B;
            default:       c = 8'h2F;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// File: design/b64e_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// b64e_front
// Accepts one byte per item, tracks the group phase and the leftover bits,
// and turns each byte into a group of one to four characters.
// ---------------------------------------------------------------------------
module b64e_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              byte_valid,
    output logic                   byte_stall,
    input  wire logic [7:0]        in_byte,
    input  wire logic              end_of_message,
    input  wire b64e_pkg::q_stat_t q_stat,
    output logic                   push,
    output b64e_pkg::grp_t         push_grp
);

    b64e_pkg::phase_t phase_reg, phase_next;
    logic [3:0]       left_reg, left_next;
    logic             take;

    assign byte_stall = q_stat.full;
    assign take       = byte_valid && !q_stat.full;
    assign push       = take;

    always_comb
    begin
        phase_next        = phase_reg;
        left_next         = left_reg;
        push_grp.chars    = {4{b64e_pkg::PAD_CHAR}};
        push_grp.last_idx = 2'd0;
        push_grp.fin      = end_of_message;
        case (phase_reg)
            b64e_pkg::PH_1:
            begin
                push_grp.chars[0] = b64e_pkg::enc6({left_reg[1:0], in_byte[7:4]});
                if (end_of_message)
                begin
                    push_grp.chars[1] = b64e_pkg::enc6({in_byte[3:0], 2'b00});
                    push_grp.last_idx = 2'd2;
                    phase_next        = b64e_pkg::PH_0;
                    left_next         = 4'd0;
                end
                else
                begin
                    phase_next = b64e_pkg::PH_2;
                    left_next  = in_byte[3:0];
                end
            end
            b64e_pkg::PH_2:
            begin
                push_grp.chars[0] = b64e_pkg::enc6({left_reg, in_byte[7:6]});
                push_grp.chars[1] = b64e_pkg::enc6(in_byte[5:0]);
                push_grp.last_idx = 2'd1;
                phase_next        = b64e_pkg::PH_0;
                left_next         = 4'd0;
            end
            default:
            begin
                push_grp.chars[0] = b64e_pkg::enc6(in_byte[7:2]);
                if (end_of_message)
                begin
                    push_grp.chars[1] = b64e_pkg::enc6({in_byte[1:0], 4'b0000});
                    push_grp.last_idx = 2'd3;
                    phase_next        = b64e_pkg::PH_0;
                    left_next         = 4'd0;
                end
                else
                begin
                    phase_next = b64e_pkg::PH_1;
                    left_next  = {2'b00, in_byte[1:0]};
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= b64e_pkg::PH_0;
            left_reg  <= 4'd0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
        end
    end

endmodule
`default_nettype wire

// File: design/b64e_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// b64e_queue
// Small register queue of character groups between the front and back parts.
// ---------------------------------------------------------------------------
module b64e_queue #(
    parameter int unsigned Depth = b64e_pkg::QUEUE_DEPTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire b64e_pkg::grp_t push_grp,
    input  wire logic           pop,
    output b64e_pkg::grp_t      head_grp,
    output b64e_pkg::q_stat_t   q_stat,
    output logic [$clog2(Depth+1)-1:0] fill
);

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);

    b64e_pkg::grp_t  mem_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            do_push, do_pop;

    assign q_stat.full  = (cnt_reg == CntW'(Depth));
    assign q_stat.empty = (cnt_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head_grp     = mem_reg[rd_ptr_reg];
    assign fill         = cnt_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_grp;
        end
    end

endmodule
`default_nettype wire

// File: design/b64e_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// b64e_back
// Walks the characters of the group at the head of the queue, one per cycle
// unless char_stall holds a valid character, into the output register.
// ---------------------------------------------------------------------------
module b64e_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire b64e_pkg::grp_t    head_grp,
    input  wire b64e_pkg::q_stat_t q_stat,
    output logic                   pop,
    output logic [1:0]             char_idx,
    output logic                   char_valid,
    input  wire logic              char_stall,
    output logic [7:0]             out_char,
    output logic                   final_char
);

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] char_reg;
    logic       fin_reg;
    logic       load, at_last;

    assign load    = !q_stat.empty && (!valid_reg || !char_stall);
    assign at_last = (idx_reg == head_grp.last_idx);
    assign pop     = load && at_last;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg && char_stall;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = at_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg <= head_grp.chars[idx_reg];
            fin_reg  <= head_grp.fin && at_last;
        end
    end

    assign char_idx   = idx_reg;
    assign char_valid = valid_reg;
    assign out_char   = char_reg;
    assign final_char = fin_reg;

endmodule
`default_nettype wire

// File: design/base64_encoder_unit.sv
`default_nettype none
// A byte's group is written into the queue; its first character is then loaded
// into the output register. One character leaves per cycle unless char_stall
// holds it; a byte gives one to four characters, a 3-byte group gives four.
// A two-group queue lets the input side run ahead of the character walk.
// Reset clears the group phase, leftover bits, queue pointers and output valid.
// ---------------------------------------------------------------------------
// base64_encoder_unit
// Streaming Base64 encoder with '=' padding and a flag on the final character.
// ---------------------------------------------------------------------------
module base64_encoder_unit #(
    parameter int unsigned QueueDepth = b64e_pkg::QUEUE_DEPTH
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       byte_valid,
    output logic            byte_stall,
    input  wire logic [7:0] in_byte,
    input  wire logic       end_of_message,
    output logic            char_valid,
    input  wire logic       char_stall,
    output logic [7:0]      out_char,
    output logic            final_char
);

    b64e_pkg::grp_t    push_grp, head_grp;
    b64e_pkg::q_stat_t q_stat;
    logic              push, pop;
    logic [1:0]        char_idx;
    logic [$clog2(QueueDepth+1)-1:0] fill;

    b64e_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_valid     (byte_valid),
        .byte_stall     (byte_stall),
        .in_byte        (in_byte),
        .end_of_message (end_of_message),
        .q_stat         (q_stat),
        .push           (push),
        .push_grp       (push_grp)
    );

    b64e_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_grp (push_grp),
        .pop      (pop),
        .head_grp (head_grp),
        .q_stat   (q_stat),
        .fill     (fill)
    );

    b64e_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_grp   (head_grp),
        .q_stat     (q_stat),
        .pop        (pop),
        .char_idx   (char_idx),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .out_char   (out_char),
        .final_char (final_char)
    );

    // The queue never holds more groups than it has room for.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill <= ($clog2(QueueDepth+1))'(QueueDepth))
        else $error("queue fill exceeds depth");

    // The input side is held off exactly when the queue is full.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall == (fill == ($clog2(QueueDepth+1))'(QueueDepth)))
        else $error("input stall does not track queue full");

    // The character walk never runs past the last character of the head group.
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !q_stat.empty |-> char_idx <= head_grp.last_idx)
        else $error("character index beyond group");

    // A group is only popped on its last character, and the walk then restarts at index zero.
    a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> char_idx == 2'd0)
        else $error("character index not restarted after pop");

endmodule
`default_nettype wire
